[rtl/tmlc_pkg.sv]
// Shared types and constants for the tiled mip layout calculator.
// No dependencies; every other file imports this package.
package tmlc_pkg;

    localparam int GOB_WIDTH_LOG2  = 6;   // 64-byte GOB rows
    localparam int GOB_HEIGHT_LOG2 = 3;   // 8 rows per GOB
    localparam int GOB_DEPTH_LOG2  = 0;   // 1 slice per GOB
    localparam int MAX_TILE_LOG2   = 5;

    localparam int PX_W     = 15;
    localparam int WB_W     = 20;
    localparam int AW_W     = 20;
    localparam int AH_W     = 16;
    localparam int DS_W     = 36;
    localparam int LS_W     = 51;
    localparam int LAYER_W  = 55;
    localparam int ASTR_W   = 56;
    localparam int ACC_W    = 64;
    localparam int MPLR_W   = 16;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_DIV_W,
        CMD_DIV_H,
        CMD_DIV_D,
        CMD_ST_W,
        CMD_ST_H,
        CMD_ST_D,
        CMD_TILE,
        CMD_DS,
        CMD_MUL_LS,
        CMD_ST_LS,
        CMD_FINAL,
        CMD_MUL_IMG,
        CMD_EMIT,
        CMD_NEXT
    } cmd_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DW, ST_DW_WT,
        ST_DH, ST_DH_WT,
        ST_DD, ST_DD_WT,
        ST_TILE, ST_DS,
        ST_MLS, ST_MLS_WT,
        ST_FIN,
        ST_MIMG, ST_MIMG_WT,
        ST_EMIT, ST_OUTW
    } state_t;

    typedef struct packed {
        logic div_done;
        logic mul_done;
        logic is_last;
        logic zero_levels;
    } status_t;

    // Ceiling log2 of n, capped at MAX_TILE_LOG2.
    function automatic logic [2:0] tile_log2(input logic [15:0] n);
        logic [2:0] k;
        k = 3'd0;
        for (int i = 0; i < MAX_TILE_LOG2; i++) begin
            if (n > (16'd1 << i)) begin
                k = 3'(i + 1);
            end
        end
        return k;
    endfunction

endpackage

[rtl/tmlc_div.sv]
// Radix-2 restoring divider giving ceil(num / den), one quotient bit per cycle.
// Depends on tmlc_pkg.
module tmlc_div
    import tmlc_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic [PX_W-1:0] num,
    input  logic [3:0]      den,
    output logic            done,
    output logic [PX_W-1:0] quot
);

    logic            run_reg, run_next;
    logic [3:0]      cnt_reg, cnt_next;
    logic [PX_W-1:0] num_reg, num_next;
    logic [PX_W-1:0] q_reg, q_next;
    logic [4:0]      rem_reg, rem_next;
    logic [3:0]      den_reg, den_next;
    logic [4:0]      trial;

    always_comb
    begin
        run_next = run_reg;
        cnt_next = cnt_reg;
        num_next = num_reg;
        q_next   = q_reg;
        rem_next = rem_reg;
        den_next = den_reg;
        trial    = {rem_reg[3:0], num_reg[PX_W-1]};
        if (start)
        begin
            run_next = 1'b1;
            cnt_next = 4'(PX_W - 1);
            num_next = num;
            q_next   = '0;
            rem_next = '0;
            den_next = (den == 4'd0) ? 4'd1 : den;
        end
        else if (run_reg)
        begin
            num_next = {num_reg[PX_W-2:0], 1'b0};
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = trial - {1'b0, den_reg};
                q_next   = {q_reg[PX_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                q_next   = {q_reg[PX_W-2:0], 1'b0};
            end
            if (cnt_reg == 4'd0)
            begin
                run_next = 1'b0;
            end
            else
            begin
                cnt_next = cnt_reg - 4'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            run_reg <= run_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        q_reg   <= q_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign done = !run_reg;
    assign quot = q_reg + PX_W'(rem_reg != 5'd0);

endmodule

[rtl/tmlc_mul.sv]
// Shift-and-add multiplier, one multiplier bit per cycle, early exit on zero.
// Depends on tmlc_pkg.
module tmlc_mul
    import tmlc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [ACC_W-1:0]  mcand,
    input  logic [MPLR_W-1:0] mplier,
    output logic              done,
    output logic [ACC_W-1:0]  prod
);

    logic              run_reg, run_next;
    logic [ACC_W-1:0]  mc_reg, mc_next;
    logic [MPLR_W-1:0] mp_reg, mp_next;
    logic [ACC_W-1:0]  acc_reg, acc_next;

    always_comb
    begin
        run_next = run_reg;
        mc_next  = mc_reg;
        mp_next  = mp_reg;
        acc_next = acc_reg;
        if (start)
        begin
            mc_next  = mcand;
            mp_next  = mplier;
            acc_next = '0;
            run_next = (mplier != '0);
        end
        else if (run_reg)
        begin
            if (mp_reg[0])
            begin
                acc_next = acc_reg + mc_reg;
            end
            mc_next  = {mc_reg[ACC_W-2:0], 1'b0};
            mp_next  = {1'b0, mp_reg[MPLR_W-1:1]};
            run_next = (mp_next != '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
        end
        else
        begin
            run_reg <= run_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mc_reg  <= mc_next;
        mp_reg  <= mp_next;
        acc_reg <= acc_next;
    end

    assign done = !run_reg;
    assign prod = acc_reg;

endmodule

[rtl/tmlc_dpath.sv]
// Datapath: input latch, per-level extent math, layer accumulation, result register.
// Depends on tmlc_pkg, tmlc_div and tmlc_mul.
module tmlc_dpath
    import tmlc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cmd_t        cmd,
    output status_t     status,
    input  logic [14:0] width_px,
    input  logic [14:0] height_px,
    input  logic [14:0] depth_px,
    input  logic [11:0] array_layers,
    input  logic [3:0]  block_width,
    input  logic [3:0]  block_height,
    input  logic [3:0]  block_depth,
    input  logic [4:0]  bytes_per_block,
    input  logic [3:0]  level_count,
    input  logic        view_2d,
    output logic [3:0]  level_index,
    output logic [47:0] offset_bytes,
    output logic [2:0]  tile_y_log2,
    output logic [2:0]  tile_z_log2,
    output logic [18:0] row_stride_bytes,
    output logic [32:0] depth_stride_bytes,
    output logic [46:0] level_bytes,
    output logic [19:0] image_align_bytes,
    output logic [47:0] array_stride_bytes,
    output logic [58:0] image_size_bytes,
    output logic        last
);

    logic [PX_W-1:0]    w_reg, h_reg, d_reg;
    logic [11:0]        layers_reg;
    logic [3:0]         bw_reg, bh_reg, bd_reg;
    logic [4:0]         bpb_reg;
    logic [3:0]         nlev_reg;
    logic               flat_reg;
    logic [3:0]         lvl_reg;
    logic [WB_W-1:0]    wb_reg;
    logic [PX_W-1:0]    hb_reg, db_reg;
    logic [2:0]         ty_reg, tz_reg;
    logic [AW_W-1:0]    aw_reg;
    logic [AH_W-1:0]    ah_reg, ad_reg;
    logic [4:0]         ae_reg;
    logic [DS_W-1:0]    ds_reg;
    logic [LS_W-1:0]    ls_reg;
    logic [LAYER_W-1:0] layer_reg;
    logic [ASTR_W-1:0]  astr_reg;

    logic               div_start, div_done, mul_start, mul_done;
    logic [PX_W-1:0]    div_num, div_q;
    logic [3:0]         div_den;
    logic [ACC_W-1:0]   mul_mcand, mul_prod;
    logic [MPLR_W-1:0]  mul_mplier;

    logic [2:0]         ty_c, tz_c;
    logic [AH_W-1:0]    hmask, dmask;
    logic [LAYER_W-1:0] total;
    logic [ASTR_W-1:0]  amask;

    always_comb
    begin
        div_start = 1'b1;
        div_num   = w_reg >> lvl_reg;
        div_den   = bw_reg;
        case (cmd)
            CMD_DIV_W:
            begin
                div_num = w_reg >> lvl_reg;
                div_den = bw_reg;
            end
            CMD_DIV_H:
            begin
                div_num = h_reg >> lvl_reg;
                div_den = bh_reg;
            end
            CMD_DIV_D:
            begin
                div_num = d_reg >> lvl_reg;
                div_den = bd_reg;
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
        if (div_num == '0)
        begin
            div_num = PX_W'(1);
        end
    end

    assign mul_start  = (cmd == CMD_MUL_LS) || (cmd == CMD_MUL_IMG);
    assign mul_mcand  = (cmd == CMD_MUL_IMG) ? ACC_W'(astr_reg) : ACC_W'(ds_reg);
    assign mul_mplier = (cmd == CMD_MUL_IMG) ? MPLR_W'(layers_reg) : ad_reg;

    tmlc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_q)
    );

    tmlc_mul u_mul (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mul_start),
        .mcand  (mul_mcand),
        .mplier (mul_mplier),
        .done   (mul_done),
        .prod   (mul_prod)
    );

    // Tile selection, alignment masks and the running layer total for the current level.
    always_comb
    begin
        ty_c  = tile_log2(16'((17'(hb_reg) + 17'(7)) >> GOB_HEIGHT_LOG2));
        tz_c  = flat_reg ? 3'd0 : tile_log2(16'(db_reg));
        hmask = (AH_W'(1) << (GOB_HEIGHT_LOG2 + 32'(ty_c))) - AH_W'(1);
        dmask = (AH_W'(1) << (GOB_DEPTH_LOG2 + 32'(tz_c))) - AH_W'(1);
        total = layer_reg + LAYER_W'(ls_reg);
        amask = (ASTR_W'(1) << ae_reg) - ASTR_W'(1);
    end

    always_ff @(posedge clk)
    begin
        case (cmd)
            CMD_LOAD:
            begin
                w_reg      <= width_px;
                h_reg      <= height_px;
                d_reg      <= depth_px;
                layers_reg <= array_layers;
                bw_reg     <= block_width;
                bh_reg     <= block_height;
                bd_reg     <= block_depth;
                bpb_reg    <= bytes_per_block;
                nlev_reg   <= level_count;
                flat_reg   <= view_2d;
                lvl_reg    <= '0;
                layer_reg  <= '0;
            end
            CMD_ST_W:
            begin
                wb_reg <= WB_W'(div_q * bpb_reg);
            end
            CMD_ST_H:
            begin
                hb_reg <= div_q;
            end
            CMD_ST_D:
            begin
                db_reg <= div_q;
            end
            CMD_TILE:
            begin
                ty_reg <= ty_c;
                tz_reg <= tz_c;
                aw_reg <= AW_W'((21'(wb_reg) + 21'(63)) >> GOB_WIDTH_LOG2) << GOB_WIDTH_LOG2;
                ah_reg <= (AH_W'(hb_reg) + hmask) & ~hmask;
                ad_reg <= (AH_W'(db_reg) + dmask) & ~dmask;
                if (lvl_reg == 4'd0)
                begin
                    ae_reg <= 5'(GOB_WIDTH_LOG2 + GOB_HEIGHT_LOG2 + GOB_DEPTH_LOG2)
                              + 5'(ty_c) + 5'(tz_c);
                end
            end
            CMD_DS:
            begin
                ds_reg <= DS_W'(aw_reg * ah_reg);
            end
            CMD_ST_LS:
            begin
                ls_reg <= mul_prod[LS_W-1:0];
            end
            CMD_FINAL:
            begin
                astr_reg <= (ASTR_W'(total) + amask) & ~amask;
            end
            CMD_EMIT:
            begin
                level_index        <= lvl_reg;
                offset_bytes       <= layer_reg[47:0];
                tile_y_log2        <= ty_reg;
                tile_z_log2        <= tz_reg;
                row_stride_bytes   <= aw_reg[18:0];
                depth_stride_bytes <= ds_reg[32:0];
                level_bytes        <= ls_reg[46:0];
                last               <= status.is_last;
                if (status.is_last)
                begin
                    image_align_bytes  <= 20'(1) << ae_reg;
                    array_stride_bytes <= astr_reg[47:0];
                    image_size_bytes   <= mul_prod[58:0];
                end
                else
                begin
                    image_align_bytes  <= '0;
                    array_stride_bytes <= '0;
                    image_size_bytes   <= '0;
                end
            end
            CMD_NEXT:
            begin
                layer_reg <= total;
                lvl_reg   <= lvl_reg + 4'd1;
            end
            default:
            begin
            end
        endcase
    end

    assign status.div_done    = div_done;
    assign status.mul_done    = mul_done;
    assign status.is_last     = (lvl_reg == (nlev_reg - 4'd1));
    assign status.zero_levels = (level_count == 4'd0);

endmodule

[rtl/tmlc_ctrl.sv]
// Controller state machine sequencing the per-level steps of the datapath.
// Depends on tmlc_pkg.
module tmlc_ctrl
    import tmlc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    output logic    out_valid,
    input  logic    out_ready,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = CMD_NONE;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd        = CMD_LOAD;
                    state_next = status.zero_levels ? ST_IDLE : ST_DW;
                end
            end
            ST_DW:
            begin
                cmd        = CMD_DIV_W;
                state_next = ST_DW_WT;
            end
            ST_DW_WT:
            begin
                if (status.div_done)
                begin
                    cmd        = CMD_ST_W;
                    state_next = ST_DH;
                end
            end
            ST_DH:
            begin
                cmd        = CMD_DIV_H;
                state_next = ST_DH_WT;
            end
            ST_DH_WT:
            begin
                if (status.div_done)
                begin
                    cmd        = CMD_ST_H;
                    state_next = ST_DD;
                end
            end
            ST_DD:
            begin
                cmd        = CMD_DIV_D;
                state_next = ST_DD_WT;
            end
            ST_DD_WT:
            begin
                if (status.div_done)
                begin
                    cmd        = CMD_ST_D;
                    state_next = ST_TILE;
                end
            end
            ST_TILE:
            begin
                cmd        = CMD_TILE;
                state_next = ST_DS;
            end
            ST_DS:
            begin
                cmd        = CMD_DS;
                state_next = ST_MLS;
            end
            ST_MLS:
            begin
                cmd        = CMD_MUL_LS;
                state_next = ST_MLS_WT;
            end
            ST_MLS_WT:
            begin
                if (status.mul_done)
                begin
                    cmd        = CMD_ST_LS;
                    state_next = status.is_last ? ST_FIN : ST_EMIT;
                end
            end
            ST_FIN:
            begin
                cmd        = CMD_FINAL;
                state_next = ST_MIMG;
            end
            ST_MIMG:
            begin
                cmd        = CMD_MUL_IMG;
                state_next = ST_MIMG_WT;
            end
            ST_MIMG_WT:
            begin
                if (status.mul_done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                cmd        = CMD_EMIT;
                state_next = ST_OUTW;
            end
            ST_OUTW:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    cmd        = CMD_NEXT;
                    state_next = status.is_last ? ST_IDLE : ST_DW;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

[rtl/tiled_mip_layout_calculator_top.sv]
// Tiled mip layout calculator: one image description in, one beat per mip level out.
// A level runs three divides (width, height, depth), tile selection and the depth stride,
// a multiply whose length is set by the aligned depth's bit count, then presents its beat.
// The last level adds the array stride and an image-size multiply set by the layer count's bit count;
// one image is in flight at a time and the next is taken the cycle after its last beat leaves.
// rst_n clears the controller asynchronously; the block then idles ready for input.
module tiled_mip_layout_calculator_top
    import tmlc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [14:0] width_px,
    input  logic [14:0] height_px,
    input  logic [14:0] depth_px,
    input  logic [11:0] array_layers,
    input  logic [3:0]  block_width,
    input  logic [3:0]  block_height,
    input  logic [3:0]  block_depth,
    input  logic [4:0]  bytes_per_block,
    input  logic [3:0]  level_count,
    input  logic        view_2d,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [3:0]  level_index,
    output logic [47:0] offset_bytes,
    output logic [2:0]  tile_y_log2,
    output logic [2:0]  tile_z_log2,
    output logic [18:0] row_stride_bytes,
    output logic [32:0] depth_stride_bytes,
    output logic [46:0] level_bytes,
    output logic [19:0] image_align_bytes,
    output logic [47:0] array_stride_bytes,
    output logic [58:0] image_size_bytes,
    output logic        last
);

    // The controller sequences divides, tile selection and multiplies per level;
    // the datapath holds all values and the registered result beat.
    cmd_t    cmd;
    status_t status;

    tmlc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    tmlc_dpath u_dpath (
        .clk                (clk),
        .rst_n              (rst_n),
        .cmd                (cmd),
        .status             (status),
        .width_px           (width_px),
        .height_px          (height_px),
        .depth_px           (depth_px),
        .array_layers       (array_layers),
        .block_width        (block_width),
        .block_height       (block_height),
        .block_depth        (block_depth),
        .bytes_per_block    (bytes_per_block),
        .level_count        (level_count),
        .view_2d            (view_2d),
        .level_index        (level_index),
        .offset_bytes       (offset_bytes),
        .tile_y_log2        (tile_y_log2),
        .tile_z_log2        (tile_z_log2),
        .row_stride_bytes   (row_stride_bytes),
        .depth_stride_bytes (depth_stride_bytes),
        .level_bytes        (level_bytes),
        .image_align_bytes  (image_align_bytes),
        .array_stride_bytes (array_stride_bytes),
        .image_size_bytes   (image_size_bytes),
        .last               (last)
    );

endmodule

[bench/tb.sv]
// Self-checking testbench for tiled_mip_layout_calculator_top.
// Predicts every per-level layout beat from each image description and compares field by field.
// Depends on tmlc_pkg and the RTL of the tiled mip layout calculator.
module tb;
    import tmlc_pkg::*;

    // Layout geometry that the predictor uses, taken from the package.
    localparam int GOB_W_BYTES = 1 << GOB_WIDTH_LOG2;
    localparam int GOB_H_ROWS  = 1 << GOB_HEIGHT_LOG2;
    localparam int GOB_D_SLC   = 1 << GOB_DEPTH_LOG2;
    localparam int LEVEL_CAP   = 15;
    localparam int LIMIT       = 2000000;

    // One image description, as offered on the input side.
    typedef struct packed {
        logic [14:0] w;
        logic [14:0] h;
        logic [14:0] d;
        logic [11:0] layers;
        logic [3:0]  bw;
        logic [3:0]  bh;
        logic [3:0]  bd;
        logic [4:0]  bpb;
        logic [3:0]  levels;
        logic        flat;
    } image_desc_t;

    // One level layout beat, as seen on the output side.
    typedef struct packed {
        logic [3:0]  lvl;
        logic [47:0] offset;
        logic [2:0]  ty;
        logic [2:0]  tz;
        logic [18:0] row_stride;
        logic [32:0] depth_stride;
        logic [46:0] lvl_bytes;
        logic [19:0] align;
        logic [47:0] array_stride;
        logic [58:0] img_size;
        logic        is_last;
    } level_layout_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [14:0] width_px;
    logic [14:0] height_px;
    logic [14:0] depth_px;
    logic [11:0] array_layers;
    logic [3:0]  block_width;
    logic [3:0]  block_height;
    logic [3:0]  block_depth;
    logic [4:0]  bytes_per_block;
    logic [3:0]  level_count;
    logic        view_2d;
    logic        out_valid;
    logic        out_ready;
    logic [3:0]  level_index;
    logic [47:0] offset_bytes;
    logic [2:0]  tile_y_log2;
    logic [2:0]  tile_z_log2;
    logic [18:0] row_stride_bytes;
    logic [32:0] depth_stride_bytes;
    logic [46:0] level_bytes;
    logic [19:0] image_align_bytes;
    logic [47:0] array_stride_bytes;
    logic [58:0] image_size_bytes;
    logic        last;

    tiled_mip_layout_calculator_top i_dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (in_valid),
        .in_ready           (in_ready),
        .width_px           (width_px),
        .height_px          (height_px),
        .depth_px           (depth_px),
        .array_layers       (array_layers),
        .block_width        (block_width),
        .block_height       (block_height),
        .block_depth        (block_depth),
        .bytes_per_block    (bytes_per_block),
        .level_count        (level_count),
        .view_2d            (view_2d),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .level_index        (level_index),
        .offset_bytes       (offset_bytes),
        .tile_y_log2        (tile_y_log2),
        .tile_z_log2        (tile_z_log2),
        .row_stride_bytes   (row_stride_bytes),
        .depth_stride_bytes (depth_stride_bytes),
        .level_bytes        (level_bytes),
        .image_align_bytes  (image_align_bytes),
        .array_stride_bytes (array_stride_bytes),
        .image_size_bytes   (image_size_bytes),
        .last               (last)
    );

    // Expected level beats, oldest first.
    level_layout_t pending_levels[$];
    int            error_count;
    int            cycle_count;
    // Idle percentages for the two sides; the active phase sets them.
    int            send_idle_pct;
    int            recv_stall_pct;
    // Cycles left in a long receiver hold-off; counted down by its own process.
    int            hold_off_cycles;

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // Run watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // Ceiling division with a zero divisor treated as one.
    function automatic logic [63:0] ceil_div(input logic [63:0] n, input logic [63:0] d);
        logic [63:0] dd;
        dd = (d == 0) ? 64'd1 : d;
        return (n + dd - 1) / dd;
    endfunction

    // Tile log2 in GOBs: ceiling log2 of the count, capped at the maximum.
    function automatic logic [2:0] gob_log2(input logic [63:0] n);
        int k;
        k = 0;
        while (k < MAX_TILE_LOG2 && (64'd1 << k) < n)
        begin
            k++;
        end
        return 3'(k);
    endfunction

    // Works out every level beat of one image and queues them in order.
    task automatic predict_layout(input image_desc_t img);
        int          nlev;
        logic [63:0] wb, hb, db, aw, ah, ad, th, td, ds, ls;
        logic [63:0] layer_total, align0, astride;
        level_layout_t beat;
        begin
            nlev = (img.levels > LEVEL_CAP) ? LEVEL_CAP : int'(img.levels);
            layer_total = 0;
            align0 = 1;
            for (int l = 0; l < nlev; l++)
            begin
                wb = ceil_div(((64'(img.w) >> l) == 0) ? 64'd1 : (64'(img.w) >> l), 64'(img.bw))
                     * 64'(img.bpb);
                hb = ceil_div(((64'(img.h) >> l) == 0) ? 64'd1 : (64'(img.h) >> l), 64'(img.bh));
                db = ceil_div(((64'(img.d) >> l) == 0) ? 64'd1 : (64'(img.d) >> l), 64'(img.bd));
                beat = '0;
                beat.lvl = 4'(l);
                beat.offset = 48'(layer_total);
                beat.ty = gob_log2(ceil_div(hb, GOB_H_ROWS));
                beat.tz = img.flat ? 3'd0 : gob_log2(ceil_div(db, GOB_D_SLC));
                th = 64'(GOB_H_ROWS) << beat.ty;
                td = 64'(GOB_D_SLC) << beat.tz;
                aw = ceil_div(wb, GOB_W_BYTES) * GOB_W_BYTES;
                ah = ceil_div(hb, th) * th;
                ad = ceil_div(db, td) * td;
                ds = aw * ah;
                ls = ds * ad;
                if (l == 0)
                begin
                    align0 = GOB_W_BYTES * th * td;
                end
                beat.row_stride = 19'(aw);
                beat.depth_stride = 33'(ds);
                beat.lvl_bytes = 47'(ls);
                layer_total += ls;
                if (l == nlev - 1)
                begin
                    astride = ceil_div(layer_total, align0) * align0;
                    beat.align = 20'(align0);
                    beat.array_stride = 48'(astride);
                    beat.img_size = 59'(astride * 64'(img.layers));
                    beat.is_last = 1'b1;
                end
                pending_levels.push_back(beat);
            end
        end
    endtask

    task automatic report_mismatch(input string what);
        begin
            $display("mismatch at cycle %0d: %s", cycle_count, what);
            error_count++;
        end
    endtask

    // Sends one image description, honoring the sender idle percentage.
    // Starts at the next falling edge and returns right after the accepting rising edge.
    task automatic send_image(input image_desc_t img);
        begin
            @(negedge clk);
            while ($urandom_range(99) < send_idle_pct)
            begin
                in_valid <= 1'b0;
                @(negedge clk);
            end
            predict_layout(img);
            in_valid <= 1'b1;
            width_px <= img.w;
            height_px <= img.h;
            depth_px <= img.d;
            array_layers <= img.layers;
            block_width <= img.bw;
            block_height <= img.bh;
            block_depth <= img.bd;
            bytes_per_block <= img.bpb;
            level_count <= img.levels;
            view_2d <= img.flat;
            @(posedge clk);
            while (!in_ready)
            begin
                @(posedge clk);
            end
        end
    endtask

    // Receiver: stalls at random or during a hold-off; checks each accepted beat.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= (hold_off_cycles == 0) && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(negedge clk)
    begin
        if (hold_off_cycles > 0)
        begin
            hold_off_cycles <= hold_off_cycles - 1;
        end
    end

    always @(posedge clk)
    begin
        level_layout_t got, want;
        if (rst_n && out_valid && out_ready)
        begin
            got = {level_index, offset_bytes, tile_y_log2, tile_z_log2, row_stride_bytes,
                   depth_stride_bytes, level_bytes, image_align_bytes, array_stride_bytes,
                   image_size_bytes, last};
            if (pending_levels.size() == 0)
            begin
                report_mismatch("level beat with none expected");
            end
            else
            begin
                want = pending_levels.pop_front();
                if (got.lvl != want.lvl)
                    report_mismatch($sformatf("level_index %0d want %0d", got.lvl, want.lvl));
                if (got.offset != want.offset)
                    report_mismatch($sformatf("offset_bytes %0d want %0d",
                                              got.offset, want.offset));
                if (got.ty != want.ty)
                    report_mismatch($sformatf("tile_y_log2 %0d want %0d", got.ty, want.ty));
                if (got.tz != want.tz)
                    report_mismatch($sformatf("tile_z_log2 %0d want %0d", got.tz, want.tz));
                if (got.row_stride != want.row_stride)
                    report_mismatch($sformatf("row_stride_bytes %0d want %0d",
                                              got.row_stride, want.row_stride));
                if (got.depth_stride != want.depth_stride)
                    report_mismatch($sformatf("depth_stride_bytes %0d want %0d",
                                              got.depth_stride, want.depth_stride));
                if (got.lvl_bytes != want.lvl_bytes)
                    report_mismatch($sformatf("level_bytes %0d want %0d",
                                              got.lvl_bytes, want.lvl_bytes));
                if (got.align != want.align)
                    report_mismatch($sformatf("image_align_bytes %0d want %0d",
                                              got.align, want.align));
                if (got.array_stride != want.array_stride)
                    report_mismatch($sformatf("array_stride_bytes %0d want %0d",
                                              got.array_stride, want.array_stride));
                if (got.img_size != want.img_size)
                    report_mismatch($sformatf("image_size_bytes %0d want %0d",
                                              got.img_size, want.img_size));
                if (got.is_last != want.is_last)
                    report_mismatch($sformatf("last %0d want %0d", got.is_last, want.is_last));
            end
        end
    end

    // Random description; most use nonzero fields in bounded ranges, with depths of at most 64.
    function automatic image_desc_t random_image();
        image_desc_t img;
        img = image_desc_t'($bits(image_desc_t)'({$urandom, $urandom, $urandom}));
        if ($urandom_range(3) != 0)
        begin
            img.w = 15'($urandom_range(1, 16384));
            img.h = 15'($urandom_range(1, 16384));
            img.d = ($urandom_range(1) != 0) ? 15'($urandom_range(1, 64)) : 15'(1);
            img.layers = 12'($urandom_range(1, 2048));
            img.bw = 4'($urandom_range(1, 12));
            img.bh = 4'($urandom_range(1, 12));
            img.bd = 4'($urandom_range(1, 12));
            img.bpb = 5'($urandom_range(1, 16));
            img.levels = 4'($urandom_range(1, 15));
        end
        return img;
    endfunction

    // Drops the input offer, waits until every expected beat has arrived, then idles a while.
    task automatic wait_drained();
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            while (pending_levels.size() != 0)
            begin
                @(posedge clk);
            end
            repeat (100) @(negedge clk);
        end
    endtask

    function automatic image_desc_t make_image(input int w, input int h, input int d,
                                               input int lay, input int bw, input int bh,
                                               input int bd, input int bpb, input int lv,
                                               input bit fl);
        image_desc_t img;
        img = '{15'(w), 15'(h), 15'(d), 12'(lay), 4'(bw), 4'(bh), 4'(bd), 5'(bpb), 4'(lv), fl};
        return img;
    endfunction

    // Extremes of every field and the named corner cases, all at full speed.
    task automatic test_directed();
        begin
            send_idle_pct = 0;
            recv_stall_pct = 0;
            send_image(make_image(1, 1, 1, 1, 1, 1, 1, 1, 1, 0));
            send_image(make_image(16384, 16384, 16384, 2048, 12, 12, 12, 16, 15, 0));
            send_image(make_image(16384, 16384, 16384, 2048, 1, 1, 1, 16, 15, 0));
            send_image(make_image(16384, 16384, 16384, 2048, 1, 1, 1, 16, 15, 1));
            send_image(make_image(32767, 32767, 32767, 4095, 15, 15, 15, 31, 15, 0));
            // Zero extents act as one pixel; zero block sizes act as one.
            send_image(make_image(0, 0, 0, 3, 0, 0, 0, 4, 4, 0));
            // Zero bytes per block gives zero sizes.
            send_image(make_image(640, 480, 8, 5, 1, 1, 1, 0, 6, 0));
            // Zero layers gives a zero image size.
            send_image(make_image(256, 256, 1, 0, 4, 4, 1, 16, 9, 1));
            // Zero levels produces no beats.
            send_image(make_image(100, 100, 100, 1, 1, 1, 1, 4, 0, 0));
            send_image(make_image(1000, 37, 300, 7, 5, 8, 6, 8, 15, 0));
            send_image(make_image(17, 9, 33, 2, 1, 1, 1, 3, 3, 0));
            send_image(make_image(4096, 1, 1, 1, 1, 1, 1, 1, 15, 1));
            send_image(make_image(1, 4096, 4096, 1, 1, 1, 1, 1, 15, 0));
            send_image(make_image(21845, 10922, 5461, 2730, 10, 5, 10, 21, 5, 1));
            wait_drained();
        end
    endtask

    // Random images under one idling pattern.
    task automatic test_random_phase(input int send_pct, input int recv_pct, input int count);
        begin
            send_idle_pct = send_pct;
            recv_stall_pct = recv_pct;
            repeat (count) send_image(random_image());
            wait_drained();
        end
    endtask

    // The receiver holds off long enough that the block must refuse new input.
    task automatic test_backpressure();
        begin
            send_idle_pct = 0;
            recv_stall_pct = 0;
            @(negedge clk);
            hold_off_cycles <= 3000;
            repeat (6) send_image(random_image());
            wait_drained();
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        width_px = '0;
        height_px = '0;
        depth_px = '0;
        array_layers = '0;
        block_width = '0;
        block_height = '0;
        block_depth = '0;
        bytes_per_block = '0;
        level_count = '0;
        view_2d = 1'b0;
        out_ready = 1'b0;
        error_count = 0;
        cycle_count = 0;
        hold_off_cycles = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_directed();
        test_random_phase(0, 0, 25);
        test_random_phase(66, 0, 20);
        test_random_phase(0, 66, 20);
        test_random_phase(17, 17, 25);
        test_backpressure();
        if (error_count == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end
endmodule

[sim.f]
rtl/tmlc_pkg.sv
rtl/tmlc_div.sv
rtl/tmlc_mul.sv
rtl/tmlc_dpath.sv
rtl/tmlc_ctrl.sv
rtl/tiled_mip_layout_calculator_top.sv
bench/tb.sv
